// ----- rtl/polc_pkg.sv -----
`default_nettype none
package polc_pkg;

  localparam int BODY_INDEX_BITS = 8;
  localparam int CORDIC_STAGES = 16;

  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032875;
  localparam logic [30:0] STIFF_RESET = 31'd32768000;

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_ANCHOR_X = 3'd5,
    REG_ANCHOR_Y = 3'd6,
    REG_STIFF    = 3'd7
  } reg_index_t;

  // Data handed from one rotation cell to the next.
  typedef struct packed {
    logic               valid;
    logic               applies;
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } cell_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0:  r = 34'sh20000000;
        5'd1:  r = 34'sh12E4051E;
        5'd2:  r = 34'sh09FB385B;
        5'd3:  r = 34'sh051111D4;
        5'd4:  r = 34'sh028B0D43;
        5'd5:  r = 34'sh0145D7E1;
        5'd6:  r = 34'sh00A2F61E;
        5'd7:  r = 34'sh00517C55;
        5'd8:  r = 34'sh0028BE53;
        5'd9:  r = 34'sh00145F2F;
        5'd10: r = 34'sh000A2F98;
        5'd11: r = 34'sh000517CC;
        5'd12: r = 34'sh00028BE6;
        5'd13: r = 34'sh000145F3;
        5'd14: r = 34'sh0000A2F9;
        5'd15: r = 34'sh0000517C;
        5'd16: r = 34'sh000028BE;
        5'd17: r = 34'sh0000145F;
        5'd18: r = 34'sh00000A2F;
        5'd19: r = 34'sh00000517;
        5'd20: r = 34'sh0000028B;
        5'd21: r = 34'sh00000145;
        5'd22: r = 34'sh000000A2;
        5'd23: r = 34'sh00000051;
        5'd24: r = 34'sh00000028;
        5'd25: r = 34'sh00000014;
        5'd26: r = 34'sh0000000A;
        5'd27: r = 34'sh00000005;
        5'd28: r = 34'sh00000002;
        5'd29: r = 34'sh00000001;
        default: r = 34'sh0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/polc_cell.sv -----
`default_nettype none
module polc_cell import polc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic [4:0] stage,
  input  wire cell_t  din,
  output cell_t       dout
);

  logic signed [33:0] ys, xs;
  logic signed [33:0] at;

  assign ys = din.y >>> stage;
  assign xs = din.x >>> stage;
  assign at = atan_entry(stage);

  // Each cell performs one micro-rotation and passes the item on.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.applies <= din.applies;
    dout.quad    <= din.quad;
    dout.pos_x   <= din.pos_x;
    dout.pos_y   <= din.pos_y;
    if (din.z >= 0) begin
      dout.x <= din.x - ys;
      dout.y <= din.y + xs;
      dout.z <= din.z - at;
    end else begin
      dout.x <= din.x + ys;
      dout.y <= din.y - xs;
      dout.z <= din.z + at;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/polc_post.sv -----
`default_nettype none
module polc_post import polc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_t              din,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic signed [31:0] anchor_x,
  input  wire logic signed [31:0] anchor_y,
  input  wire logic [30:0]        stiffness,
  output logic                    done,
  output logic                    applies,
  output logic signed [31:0]      spring_term,
  output logic signed [31:0]      jac_x,
  output logic signed [31:0]      jac_y,
  output logic signed [31:0]      jac_angle,
  output logic signed [31:0]      hess_angle
);

  // Stage A: quadrant fix and the four rotation products.
  logic signed [33:0] c_q, s_q;
  always_comb begin
    case (din.quad)
      2'd0: begin c_q = din.x;  s_q = din.y;  end
      2'd1: begin c_q = -din.y; s_q = din.x;  end
      2'd2: begin c_q = -din.x; s_q = -din.y; end
      default: begin c_q = din.y; s_q = -din.x; end
    endcase
  end

  logic a_v, a_ap;
  logic signed [31:0] a_px, a_py;
  logic signed [65:0] a_xc, a_ys, a_xs, a_yc;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else a_v <= din.valid;
    a_ap <= din.applies;
    a_px <= din.pos_x;
    a_py <= din.pos_y;
    a_xc <= 66'(anchor_x) * 66'(c_q);
    a_ys <= 66'(anchor_y) * 66'(s_q);
    a_xs <= 66'(anchor_x) * 66'(s_q);
    a_yc <= 66'(anchor_y) * 66'(c_q);
  end

  // Stage B: rounded rotated anchor and clamped offsets from the line origin.
  logic signed [66:0] rx_w, ry_w;
  logic signed [63:0] dx_w, dy_w;
  assign rx_w = (67'(a_xc) - 67'(a_ys) + 67'sd536870912) >>> 30;
  assign ry_w = (67'(a_xs) + 67'(a_yc) + 67'sd536870912) >>> 30;
  assign dx_w = 64'(a_px) + 64'(rx_w) - 64'(origin_x);
  assign dy_w = 64'(a_py) + 64'(ry_w) - 64'(origin_y);

  logic b_v, b_ap;
  logic signed [35:0] b_rx, b_ry;
  logic signed [31:0] b_dx, b_dy;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    b_ap <= a_ap;
    b_rx <= rx_w[35:0];
    b_ry <= ry_w[35:0];
    b_dx <= sat32(dx_w);
    b_dy <= sat32(dy_w);
  end

  // Stage C: six products with the line normal, each floored to Q16.16.
  logic signed [32:0] npx, npy;
  assign npx = -33'(dir_y);
  assign npy = 33'(dir_x);

  logic c_v, c_ap;
  logic signed [52:0] c_pdx, c_pdy, c_prx, c_pry, c_qrx, c_qry;
  logic signed [68:0] m_pdx, m_pdy, m_prx, m_pry, m_qrx, m_qry;
  assign m_pdx = 69'(npx) * 69'(b_dx);
  assign m_pdy = 69'(npy) * 69'(b_dy);
  assign m_prx = 69'(npx) * 69'(b_rx);
  assign m_pry = 69'(npx) * 69'(b_ry);
  assign m_qrx = 69'(npy) * 69'(b_rx);
  assign m_qry = 69'(npy) * 69'(b_ry);
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else c_v <= b_v;
    c_ap  <= b_ap;
    c_pdx <= m_pdx[68:16];
    c_pdy <= m_pdy[68:16];
    c_prx <= m_prx[68:16];
    c_pry <= m_pry[68:16];
    c_qrx <= m_qrx[68:16];
    c_qry <= m_qry[68:16];
  end

  // Stage D: sums; violation magnitude split for the stiffness scale.
  logic signed [53:0] viol_w, ja_w, ha_w;
  assign viol_w = 54'(c_pdx) + 54'(c_pdy);
  assign ja_w   = 54'(c_qrx) - 54'(c_pry);
  assign ha_w   = -54'(c_prx) - 54'(c_qry);

  logic d_v, d_ap, d_neg;
  logic [53:0] d_mag;
  logic signed [31:0] d_ja, d_ha;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else d_v <= c_v;
    d_ap  <= c_ap;
    d_neg <= viol_w < 0;
    d_mag <= (viol_w < 0) ? 54'(-viol_w) : 54'(viol_w);
    d_ja  <= sat32(64'(ja_w));
    d_ha  <= sat32(64'(ha_w));
  end

  // Stage E: magnitude times integer and fraction parts of stiffness.
  logic [14:0] kh;
  logic [15:0] kl;
  assign kh = stiffness[30:16];
  assign kl = stiffness[15:0];

  logic e_v, e_ap, e_neg;
  logic [68:0] e_hi;
  logic [69:0] e_lo;
  logic signed [31:0] e_ja, e_ha;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else e_v <= d_v;
    e_ap  <= d_ap;
    e_neg <= d_neg;
    e_hi  <= 69'(d_mag) * 69'(kh);
    e_lo  <= 70'(d_mag) * 70'(kl);
    e_ja  <= d_ja;
    e_ha  <= d_ha;
  end

  logic [70:0] mag_w;
  logic signed [31:0] spring_w;
  always_comb begin
    if (e_hi > 69'h80000000) mag_w = 71'h80000000;
    else mag_w = 71'(e_hi) + 71'(e_lo[69:16]);
    if (e_neg) begin
      if (mag_w >= 71'h80000000) spring_w = 32'sh80000000;
      else spring_w = -(32'(mag_w));
    end else begin
      if (mag_w > 71'h7FFFFFFF) spring_w = 32'sh7FFFFFFF;
      else spring_w = 32'(mag_w);
    end
  end

  logic signed [31:0] jx_w, jy_w;
  assign jx_w = sat32(64'(npx));
  assign jy_w = dir_x;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= e_v;
    applies     <= e_ap;
    spring_term <= e_ap ? spring_w : 32'sd0;
    jac_x       <= e_ap ? jx_w : 32'sd0;
    jac_y       <= e_ap ? jy_w : 32'sd0;
    jac_angle   <= e_ap ? e_ja : 32'sd0;
    hess_angle  <= e_ap ? e_ha : 32'sd0;
  end

endmodule
`default_nettype wire

// ----- rtl/point_on_line_constraint_eval_top.sv -----
// Channel  | Signals                               | Transfer rule
// config   | cfg_we, cfg_index, cfg_data           | written at any edge with cfg_we
// input    | start, busy, body_index, pos_*, angle | start high and busy low
// result   | done, applies, spring_term, jac_*,    | done high for one cycle
//          | hess_angle                            |
// The block accepts one item per clock; busy stays low.
// Each item passes through the rotation cell chain and then the six register
// stages after it (five arithmetic stages and the output).
// rst is synchronous and active high; it clears all valid flags and resets
// the configuration registers, with stiffness returning to 500.0.
// The receiver cannot stall, so results leave on a fixed schedule.
`default_nettype none
module point_on_line_constraint_eval_top import polc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  body_index,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] angle,
  output logic             done,
  output logic             applies,
  output logic signed [31:0] spring_term,
  output logic signed [31:0] jac_x,
  output logic signed [31:0] jac_y,
  output logic signed [31:0] jac_angle,
  output logic signed [31:0] hess_angle
);

  logic [7:0] target_body;
  logic signed [31:0] origin_x, origin_y, dir_x, dir_y, anchor_x, anchor_y;
  logic [30:0] stiffness;

  // Configuration registers; every index of the three-bit port is a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_body <= '0;
      origin_x <= '0;
      origin_y <= '0;
      dir_x <= '0;
      dir_y <= '0;
      anchor_x <= '0;
      anchor_y <= '0;
      stiffness <= STIFF_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TARGET:   target_body <= cfg_data[7:0];
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_DIR_X:    dir_x <= cfg_data;
        REG_DIR_Y:    dir_y <= cfg_data;
        REG_ANCHOR_X: anchor_x <= cfg_data;
        REG_ANCHOR_Y: anchor_y <= cfg_data;
        REG_STIFF:    stiffness <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Fold the angle into a quadrant and a residual within one eighth turn.
  logic [31:0] t;
  assign t = angle + 32'h20000000;

  cell_t chain [0:CORDIC_STAGES];

  always_comb begin
    chain[0].valid   = start;
    chain[0].applies = body_index[BODY_INDEX_BITS-1:0] == target_body[BODY_INDEX_BITS-1:0];
    chain[0].quad    = t[31:30];
    chain[0].x       = INV_GAIN_Q30;
    chain[0].y       = '0;
    chain[0].z       = 34'({4'b0, t[29:0]}) - 34'sh20000000;
    chain[0].pos_x   = pos_x;
    chain[0].pos_y   = pos_y;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    polc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .stage(5'(g)),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  polc_post u_post (
    .clk        (clk),
    .rst        (rst),
    .din        (chain[CORDIC_STAGES]),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .anchor_x   (anchor_x),
    .anchor_y   (anchor_y),
    .stiffness  (stiffness),
    .done       (done),
    .applies    (applies),
    .spring_term(spring_term),
    .jac_x      (jac_x),
    .jac_y      (jac_y),
    .jac_angle  (jac_angle),
    .hess_angle (hess_angle)
  );

endmodule
`default_nettype wire
